@@ hw/rtl/rala_pkg.sv @@
// Shared types and constants for the resizable array locate and resize block.
package rala_pkg;

  localparam int unsigned CapacityDefault  = 1024;
  localparam int unsigned DataWidthDefault = 32;

  localparam logic [2:0] CmdGet     = 3'd0;
  localparam logic [2:0] CmdInsert  = 3'd1;
  localparam logic [2:0] CmdDelete  = 3'd2;
  localparam logic [2:0] CmdCompare = 3'd3;
  localparam logic [2:0] CmdGrow    = 3'd4;
  localparam logic [2:0] CmdShrink  = 3'd5;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StAbsent = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;
  localparam logic [1:0] StEmpty  = 2'd3;

  localparam logic [1:0] CmpEqual   = 2'd0;
  localparam logic [1:0] CmpLess    = 2'd1;
  localparam logic [1:0] CmpGreater = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [9:0]  element_index;
    logic [31:0] write_value;
  } rala_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [1:0]  compare_result;
    logic [6:0]  block_number;
    logic [9:0]  block_offset;
    logic [10:0] element_count;
  } rala_out_t;

endpackage

@@ hw/rtl/resizable_array_locate_and_resize.sv @@
// Top level of the resizable array locate and resize block.
// One command transaction in, one result transaction out. Elements live in a
// single-port-write RAM of CAPACITY words. Get, delete, compare and shrink step
// through accept, RAM read and result. Grow steps through accept, execute, grow
// and result, plus a sweep that zeroes a newly allocated block one word per
// cycle. Insert steps through accept, execute, write and result when its block
// exists; otherwise it runs grow steps (block check, grow) until the addressed
// block exists, each allocation adding its zeroing sweep, then writes. A result
// waiting on the output holds the next command off. Entry 0 reads as zero until
// first written; every other entry is zeroed when its block is allocated.
module resizable_array_locate_and_resize
  import rala_pkg::*;
#(
  parameter int unsigned CAPACITY   = CapacityDefault,
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rala_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rala_out_t out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1) + 1;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_GROW = 3'd2;
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  // latched command
  logic [2:0]            cmd_q;
  logic [AW-1:0]         addr_q;
  logic                  inside_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [7:0]            blk_q;
  logic [9:0]            off_q;

  // result staging
  logic [1:0]  status_q, status_d;
  logic [31:0] rd_q, rd_d;
  logic [1:0]  cmp_q, cmp_d;

  // bookkeeping
  logic [CW-1:0] last_q, last_d;
  logic [CW-1:0] bs_q, bs_d;
  logic [5:0]    sbc_q, sbc_d;
  logic [CW-1:0] sbs_q, sbs_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] usable_q, usable_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] zptr_q, zptr_d;
  logic [CW-1:0] zend_q, zend_d;
  logic          z0_q, z0_d;   // entry 0 written since reset

  logic      out_valid_q;
  rala_out_t out_q;

  // locate and input decode
  logic [7:0]  loc_blk;
  logic [9:0]  loc_off;
  logic [31:0] idx32;
  logic [63:0] wv64;

  rala_locate u_locate (
    .idx_i (in_data_i.element_index),
    .blk_o (loc_blk),
    .off_o (loc_off)
  );

  assign idx32 = 32'(in_data_i.element_index);
  assign wv64  = 64'(in_data_i.write_value);

  // RAM
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] rd_fixed;
  logic [63:0]           rd64;

  rala_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (idx32[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign rd_fixed = (addr_q == '0 && !z0_q) ? '0 : rd_data;
  assign rd64     = 64'(rd_fixed);

  logic accept;
  logic absent;
  logic [CW-1:0] nbs;
  logic [CW-1:0] nsbs;
  logic [5:0]    nsbc;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign absent     = (CW'(blk_q) > last_q);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    rd_d     = rd_q;
    cmp_d    = cmp_q;
    last_d   = last_q;
    bs_d     = bs_q;
    sbc_d    = sbc_q;
    sbs_d    = sbs_q;
    fill_d   = fill_q;
    usable_d = usable_q;
    total_d  = total_q;
    zptr_d   = zptr_q;
    zend_d   = zend_q;
    z0_d     = z0_q;
    wr_en    = 1'b0;
    wr_addr  = addr_q;
    wr_data  = '0;
    nbs      = bs_q;
    nsbs     = sbs_q;
    nsbc     = sbc_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = StOk;
          rd_d     = '0;
          cmp_d    = CmpEqual;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        case (cmd_q)
          CmdGet: begin
            if (!inside_q || absent) status_d = StAbsent;
            else rd_d = rd64[31:0];
          end
          CmdDelete: begin
            if (!inside_q || absent) begin
              status_d = StAbsent;
            end else begin
              wr_en = 1'b1;
              if (addr_q == '0) z0_d = 1'b1;
            end
          end
          CmdCompare: begin
            if (!inside_q || absent) status_d = StAbsent;
            else if (rd_fixed == val_q) cmp_d = CmpEqual;
            else if (rd_fixed < val_q) cmp_d = CmpLess;
            else cmp_d = CmpGreater;
          end
          CmdInsert: begin
            if (!inside_q) status_d = StFull;
            else state_d = S_INS;
          end
          CmdGrow: state_d = S_GROW;
          CmdShrink: begin
            if (total_q == '0) begin
              status_d = StEmpty;
            end else begin
              if (total_q != CW'(1) && last_q != '0 &&
                  usable_q - bs_q == total_q - CW'(1)) begin
                usable_d = usable_q - bs_q;
                last_d   = last_q - CW'(1);
                if (fill_q == '0) begin
                  nsbc  = sbc_q - 6'd1;
                  sbc_d = nsbc;
                  if (nsbc[0]) begin
                    bs_d   = bs_q >> 1;
                    fill_d = sbs_q - CW'(1);
                  end else begin
                    sbs_d  = sbs_q >> 1;
                    fill_d = (sbs_q >> 1) - CW'(1);
                  end
                end else begin
                  fill_d = fill_q - CW'(1);
                end
              end
              total_d = total_q - CW'(1);
            end
          end
          default: ;
        endcase
      end
      S_INS: begin
        if (absent) begin
          state_d = S_GROW;
        end else begin
          wr_en   = 1'b1;
          wr_data = val_q;
          if (addr_q == '0) z0_d = 1'b1;
          state_d = S_FIN;
        end
      end
      S_GROW: begin
        if (total_q >= CapC) begin
          status_d = StFull;
          state_d  = S_FIN;
        end else if (total_q == usable_q) begin
          // allocate a new block, then sweep it to zero
          if (fill_q + CW'(1) == sbs_q) begin
            nsbc  = sbc_q + 6'd1;
            sbc_d = nsbc;
            if (nsbc[0]) nsbs = sbs_q << 1;
            else nbs = bs_q << 1;
            fill_d = '0;
          end else begin
            fill_d = fill_q + CW'(1);
          end
          bs_d     = nbs;
          sbs_d    = nsbs;
          last_d   = last_q + CW'(1);
          zptr_d   = usable_q;
          zend_d   = usable_q + nbs;
          usable_d = usable_q + nbs;
          state_d  = S_ZERO;
        end else begin
          total_d = total_q + CW'(1);
          state_d = (cmd_q == CmdInsert) ? S_INS : S_FIN;
        end
      end
      S_ZERO: begin
        if (zptr_q < CapC) begin
          wr_en   = 1'b1;
          wr_addr = zptr_q[AW-1:0];
        end
        zptr_d = zptr_q + CW'(1);
        if (zptr_q + CW'(1) == zend_q) begin
          total_d = total_q + CW'(1);
          state_d = (cmd_q == CmdInsert) ? S_INS : S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      bs_q        <= CW'(1);
      sbc_q       <= 6'd1;
      sbs_q       <= CW'(1);
      fill_q      <= '0;
      usable_q    <= CW'(1);
      total_q     <= '0;
      z0_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      last_q   <= last_d;
      bs_q     <= bs_d;
      sbc_q    <= sbc_d;
      sbs_q    <= sbs_d;
      fill_q   <= fill_d;
      usable_q <= usable_d;
      total_q  <= total_d;
      z0_q     <= z0_d;
      if (state_q == S_FIN && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rd_q     <= rd_d;
    cmp_q    <= cmp_d;
    zptr_q   <= zptr_d;
    zend_q   <= zend_d;
    if (accept) begin
      cmd_q    <= in_data_i.command;
      addr_q   <= idx32[AW-1:0];
      inside_q <= (idx32 < CAPACITY);
      val_q    <= wv64[DATA_WIDTH-1:0];
      if (in_data_i.command <= CmdCompare) begin
        blk_q <= loc_blk;
        off_q <= loc_off;
      end else begin
        blk_q <= '0;
        off_q <= '0;
      end
    end
    if (state_q == S_FIN && (!out_valid_q || out_ready_i)) begin
      out_q.status         <= status_q;
      out_q.read_value     <= rd_q;
      out_q.compare_result <= cmp_q;
      out_q.block_number   <= blk_q[6:0];
      out_q.block_offset   <= off_q;
      out_q.element_count  <= 11'(total_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/rala_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module rala_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

@@ hw/rtl/rala_locate.sv @@
// Maps an element index to its data block number and offset.
module rala_locate (
  input  logic [9:0] idx_i,
  output logic [7:0] blk_o,
  output logic [9:0] off_o
);

  logic [10:0] r;
  logic [3:0]  k;
  logic [3:0]  half;
  logic [3:0]  up;
  logic [11:0] b;
  logic [11:0] e;
  logic [11:0] p;
  logic [11:0] sum;

  always_comb begin
    r = 11'(idx_i) + 11'd1;
    k = 4'd0;
    for (int i = 1; i < 11; i++) begin
      if (r[i]) k = 4'(i);
    end
    half = k >> 1;
    up   = k - half;
    b    = (12'(r) >> up) & ((12'd1 << half) - 12'd1);
    e    = 12'(r) & ((12'd1 << up) - 12'd1);
    p    = (12'd1 << (half + 4'd1)) - 12'd2 + (k[0] ? (12'd1 << half) : 12'd0);
    sum  = p + b;
    blk_o = sum[7:0];
    off_o = e[9:0];
  end

endmodule
